// ===== sv/ipid_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipid_pkg
// Shared types, register map, widths and reset values of the incremental
// PID duty controller.
// ---------------------------------------------------------------------------
package ipid_pkg;

	// Default sizing
	localparam int CHANNELS_DEFAULT    = 2;
	localparam int SPEED_WIDTH_DEFAULT = 16;

	// Fixed field widths
	localparam int GAIN_W    = 16;
	localparam int DUTY_W    = 8;
	localparam int FRAC_BITS = 8;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = GAIN_W;

	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_CEIL  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_FLOOR = 3'd4;

	// Register reset values (gains in unsigned Q8.8)
	localparam logic [GAIN_W-1:0] GAIN_P_RESET     = 16'd77;
	localparam logic [GAIN_W-1:0] GAIN_I_RESET     = 16'd26;
	localparam logic [GAIN_W-1:0] GAIN_D_RESET     = 16'd128;
	localparam logic [DUTY_W-1:0] DUTY_CEIL_RESET  = 8'd100;
	localparam logic [DUTY_W-1:0] DUTY_FLOOR_RESET = 8'd45;

	// Result queue; depth must be a power of two
	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	// Clamp report
	typedef enum logic [1:0] {
		LIMIT_NONE  = 2'd0,
		LIMIT_CEIL  = 2'd1,
		LIMIT_FLOOR = 2'd2
	} limit_t;

endpackage

// ===== sv/ipid_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipid_in_if
// Input channel: one speed sample for one motor loop.
// ---------------------------------------------------------------------------
interface ipid_in_if import ipid_pkg::*; #(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEFAULT
) ();
	logic                          valid;
	logic                          ready;
	logic                          channel;
	logic signed [SPEED_WIDTH-1:0] measured_speed;
	logic signed [SPEED_WIDTH-1:0] target_speed;

	modport source (output valid, channel, measured_speed, target_speed, input ready);
	modport sink   (input valid, channel, measured_speed, target_speed, output ready);
endinterface

// ===== sv/ipid_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipid_out_if
// Output channel: clamped duty and clamp report for one sample.
// ---------------------------------------------------------------------------
interface ipid_out_if import ipid_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty;
	logic [1:0]        limit_hit;

	modport source (output valid, duty, limit_hit, input ready);
	modport sink   (input valid, duty, limit_hit, output ready);
endinterface

// ===== sv/ipid_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipid_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ---------------------------------------------------------------------------
module ipid_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 2,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/incremental_pid_duty_controller_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// incremental_pid_duty_controller_core
// Velocity-form PID duty controller for several motor loops, with per-loop
// error history and duty held in two small synchronous RAMs.
// ---------------------------------------------------------------------------
// Takes one sample per clock while input ready is high, also back to back
// on the same loop. A sample spends four pipeline stages (error and history,
// gain multiplies, product sum, duty update and clamp) and its result is then
// written into the result queue. The loop-carried duty update closes in the
// last stage; the history RAM and the duty RAM are each read one stage ahead
// of their use and results of the sample just ahead are forwarded. Results
// wait in an eight-entry queue; input ready drops only when eight samples are
// pending. Never-written loop entries read as zero through per-entry valid
// flags, so no clearing pass follows reset.
// ---------------------------------------------------------------------------
module incremental_pid_duty_controller_core import ipid_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEFAULT,
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	ipid_in_if.sink                in_bus,
	ipid_out_if.source             out_bus
);

	localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EW     = SPEED_WIDTH + 1;      // error
	localparam int DPW    = SPEED_WIDTH + 2;      // first difference
	localparam int DDW    = SPEED_WIDTH + 3;      // second difference
	localparam int GSW    = GAIN_W + 1;           // gain as signed operand
	localparam int PPW    = DPW + GSW;
	localparam int PIW    = EW + GSW;
	localparam int PDW    = DDW + GSW;
	localparam int AW     = DDW + GSW + 2;        // signed Q30.8 product sum (default width)
	localparam int QW     = AW - FRAC_BITS;       // integer part
	localparam int ERAM_W = 2 * EW;

	// Configuration registers
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [DUTY_W-1:0] duty_ceil_q, duty_floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= GAIN_P_RESET;
			gain_i_q     <= GAIN_I_RESET;
			gain_d_q     <= GAIN_D_RESET;
			duty_ceil_q  <= DUTY_CEIL_RESET;
			duty_floor_q <= DUTY_FLOOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:     gain_p_q     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:     gain_i_q     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:     gain_d_q     <= cfg_data[GAIN_W-1:0];
				REG_DUTY_CEIL:  duty_ceil_q  <= cfg_data[DUTY_W-1:0];
				REG_DUTY_FLOOR: duty_floor_q <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [CHANNELS-1:0] err_vld_q, duty_vld_q;
	logic [OUT_CW-1:0]   count_q;
	logic [2:0]          inflight;
	logic [OUT_CW-1:0]   pending;
	logic                in_fire, out_fire;

	assign in_fire  = in_bus.valid && in_bus.ready;
	assign out_fire = out_bus.valid && out_bus.ready;
	assign inflight = 3'(vld_s1) + 3'(vld_s2) + 3'(vld_s3) + 3'(vld_s4);
	assign pending  = count_q + OUT_CW'(inflight);
	assign in_bus.ready = (pending < OUT_CW'(OUT_DEPTH));

	// Accept: loop index and new error
	logic [CH_AW-1:0]     ch_in;
	logic signed [EW-1:0] e_in;

	assign ch_in = (CHANNELS > 1) ? CH_AW'(in_bus.channel) : '0;
	assign e_in  = EW'(in_bus.target_speed) - EW'(in_bus.measured_speed);

	// Stage 1: error history from RAM, from the sample just ahead, or zero if never written
	logic [CH_AW-1:0]     ch_s1, ch_s2, ch_s3, ch_s4, ch_s5;
	logic signed [EW-1:0] e_s1, e_s2, e1_s2;
	logic                 errv_s1;
	logic [ERAM_W-1:0]    err_rd;
	logic                 fwd_err;
	logic signed [EW-1:0] e1_res, e2_res;
	logic signed [DPW-1:0] dp, dp_s2;
	logic signed [DDW-1:0] dd, dd_s2;

	ipid_ram #(
		.WIDTH (ERAM_W),
		.DEPTH (CHANNELS),
		.ADDR_W(CH_AW)
	) u_err_ram (
		.clk  (clk),
		.we   (vld_s1),
		.waddr(ch_s1),
		.wdata({e_s1, e1_res}),
		.raddr(ch_in),
		.rdata(err_rd)
	);

	assign fwd_err = vld_s2 && (ch_s2 == ch_s1);

	always_comb begin
		if (fwd_err) begin
			e1_res = e_s2;
			e2_res = e1_s2;
		end else if (errv_s1) begin
			e1_res = err_rd[ERAM_W-1:EW];
			e2_res = err_rd[EW-1:0];
		end else begin
			e1_res = '0;
			e2_res = '0;
		end
	end

	assign dp = DPW'(e_s1) - DPW'(e1_res);
	assign dd = DDW'(e_s1) - (DDW'(e1_res) <<< 1) + DDW'(e2_res);

	// Stage 2: gain multiplies
	logic signed [GSW-1:0] gp_s, gi_s, gd_s;
	logic signed [PPW-1:0] pp, pp_s3;
	logic signed [PIW-1:0] pi, pi_s3;
	logic signed [PDW-1:0] pd, pd_s3;

	assign gp_s = $signed({1'b0, gain_p_q});
	assign gi_s = $signed({1'b0, gain_i_q});
	assign gd_s = $signed({1'b0, gain_d_q});
	assign pp   = dp_s2 * gp_s;
	assign pi   = e_s2 * gi_s;
	assign pd   = dd_s2 * gd_s;

	// Stage 3: product sum, split into integer part and fraction flag
	logic signed [AW-1:0] psum;
	logic signed [QW-1:0] q_s4;
	logic                 rnz_s4;
	logic                 dutyv_s4;
	logic [DUTY_W-1:0]    duty_rd;

	assign psum = AW'(pp_s3) + AW'(pi_s3) + AW'(pd_s3);

	// Stage 4: add held duty, truncate toward zero, clamp
	logic [DUTY_W-1:0]    duty_s5, duty_old, duty_new;
	logic signed [QW-1:0] sum, val, clip, ceil_ext, floor_ext;
	limit_t               flag;

	ipid_ram #(
		.WIDTH (DUTY_W),
		.DEPTH (CHANNELS),
		.ADDR_W(CH_AW)
	) u_duty_ram (
		.clk  (clk),
		.we   (vld_s4),
		.waddr(ch_s4),
		.wdata(duty_new),
		.raddr(ch_s3),
		.rdata(duty_rd)
	);

	always_comb begin
		if (vld_s5 && (ch_s5 == ch_s4)) begin
			duty_old = duty_s5;
		end else if (dutyv_s4) begin
			duty_old = duty_rd;
		end else begin
			duty_old = '0;
		end
	end

	// Held duty is a whole number, so the fraction only matters below zero
	assign sum       = q_s4 + QW'(duty_old);
	assign val       = sum + QW'(sum[QW-1] && rnz_s4);
	assign ceil_ext  = QW'(duty_ceil_q);
	assign floor_ext = QW'(duty_floor_q);

	// Ceiling first, then floor; floor wins when the band is inverted
	always_comb begin
		clip = val;
		flag = LIMIT_NONE;
		if (val > ceil_ext) begin
			clip = ceil_ext;
			flag = LIMIT_CEIL;
		end
		if (clip < floor_ext) begin
			clip = floor_ext;
			flag = LIMIT_FLOOR;
		end
	end

	assign duty_new = clip[DUTY_W-1:0];

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			err_vld_q  <= '0;
			duty_vld_q <= '0;
		end else begin
			vld_s1 <= in_fire;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			if (vld_s1) begin
				err_vld_q[ch_s1] <= 1'b1;
			end
			if (vld_s4) begin
				duty_vld_q[ch_s4] <= 1'b1;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		ch_s1    <= ch_in;
		e_s1     <= e_in;
		errv_s1  <= err_vld_q[ch_in];
		ch_s2    <= ch_s1;
		e_s2     <= e_s1;
		e1_s2    <= e1_res;
		dp_s2    <= dp;
		dd_s2    <= dd;
		ch_s3    <= ch_s2;
		pp_s3    <= pp;
		pi_s3    <= pi;
		pd_s3    <= pd;
		ch_s4    <= ch_s3;
		q_s4     <= psum[AW-1:FRAC_BITS];
		rnz_s4   <= |psum[FRAC_BITS-1:0];
		dutyv_s4 <= duty_vld_q[ch_s3];
		ch_s5    <= ch_s4;
		duty_s5  <= duty_new;
	end

	// Result queue
	logic [DUTY_W-1:0] fifo_duty_q [OUT_DEPTH];
	limit_t            fifo_flag_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wr_ptr_q, rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (vld_s4) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OUT_CW'(vld_s4) - OUT_CW'(out_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			fifo_duty_q[wr_ptr_q] <= duty_new;
			fifo_flag_q[wr_ptr_q] <= flag;
		end
	end

	assign out_bus.valid     = (count_q != '0);
	assign out_bus.duty      = fifo_duty_q[rd_ptr_q];
	assign out_bus.limit_hit = fifo_flag_q[rd_ptr_q];

endmodule

// ===== sv/ipid_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipid_checker
// Port-level checks of the duty controller: stall hold, results against
// accepted items, input back-pressure and clamp consistency.
// ---------------------------------------------------------------------------
module ipid_checker import ipid_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [DUTY_W-1:0]      out_duty,
	input logic [1:0]             out_limit,
	input logic                   cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [OUT_CW-1:0] pending_q;
	logic [DUTY_W-1:0] ceil_q, floor_q;

	// Items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + OUT_CW'(in_valid && in_ready)
				- OUT_CW'(out_valid && out_ready);
		end
	end

	// Shadow of the clamp band
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q  <= DUTY_CEIL_RESET;
			floor_q <= DUTY_FLOOR_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_DUTY_CEIL) begin
				ceil_q <= cfg_data[DUTY_W-1:0];
			end
			if (cfg_index == REG_DUTY_FLOOR) begin
				floor_q <= cfg_data[DUTY_W-1:0];
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_duty) && $stable(out_limit))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without an accepted item");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q < OUT_CW'(OUT_DEPTH) |-> in_ready)
		else $error("input refused with queue room left");

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_limit != LIMIT_CEIL || out_duty == ceil_q)
			&& (out_limit != LIMIT_FLOOR || out_duty == floor_q))
		else $error("clamped duty differs from its limit");

	a_band: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_limit == LIMIT_NONE |-> out_duty <= ceil_q && out_duty >= floor_q)
		else $error("unclamped duty outside band");

endmodule

bind incremental_pid_duty_controller_core ipid_checker u_ipid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_bus.valid),
	.in_ready (in_bus.ready),
	.out_valid(out_bus.valid),
	.out_ready(out_bus.ready),
	.out_duty (out_bus.duty),
	.out_limit(out_bus.limit_hit),
	.cfg_we   (cfg_we),
	.cfg_index(cfg_index),
	.cfg_data (cfg_data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the incremental PID duty controller core. A
// directed table covers reset values, speed extremes, every clamp outcome,
// floor set above ceiling and truncation of negative sums. Several random
// register settings follow, each with a run of samples. Every accepted
// sample is run through a local duty predictor. Each result is checked in
// order against the queue of expected duties. Both handshakes idle at
// random, and a long output stall backs up the pipeline.
// ---------------------------------------------------------------------------
module tb_top;
	import ipid_pkg::*;

	localparam int SPEED_W      = SPEED_WIDTH_DEFAULT;
	localparam int LOOPS        = CHANNELS_DEFAULT;
	localparam int PHASES       = 8;
	localparam int RANDOM_ITEMS = 1830;
	localparam int HOLD_CYCLES  = 80;
	localparam int TAIL_CYCLES  = 20;
	localparam int QUIET_LIMIT  = 2000;

	localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

	typedef struct {
		logic                      ch;
		logic signed [SPEED_W-1:0] meas;
		logic signed [SPEED_W-1:0] targ;
	} sample_t;

	typedef struct {
		logic [DUTY_W-1:0] duty;
		limit_t            limit;
	} duty_result_t;

	typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		sample_t                smp;
		bit                     typed;
		duty_result_t           res;
		logic [CFG_INDEX_W-1:0] reg_index;
		logic [CFG_DATA_W-1:0]  reg_data;
	} stim_row_t;

	typedef enum {STYLE_TYPICAL, STYLE_RANDOM, STYLE_EXTREME, STYLE_WIDE} cfg_style_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	ipid_in_if #(.SPEED_WIDTH(SPEED_W)) in_bus ();
	ipid_out_if                         out_bus ();

	incremental_pid_duty_controller_core #(
		.CHANNELS    (LOOPS),
		.SPEED_WIDTH (SPEED_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_bus    (in_bus),
		.out_bus   (out_bus)
	);

	// Predictor copy of registers and per-loop history
	logic [GAIN_W-1:0] gain_p     = GAIN_P_RESET;
	logic [GAIN_W-1:0] gain_i     = GAIN_I_RESET;
	logic [GAIN_W-1:0] gain_d     = GAIN_D_RESET;
	logic [DUTY_W-1:0] duty_ceil  = DUTY_CEIL_RESET;
	logic [DUTY_W-1:0] duty_floor = DUTY_FLOOR_RESET;
	longint            err_prev[LOOPS];
	longint            err_prev2[LOOPS];
	logic [DUTY_W-1:0] duty_held[LOOPS];

	duty_result_t duty_expected[$];
	stim_row_t    directed_rows[$];
	int           mismatches = 0;
	int           results_seen = 0;
	int           quiet_cycles = 0;
	bit           no_idle = 1'b0;
	bit           hold_request = 1'b0;
	bit           hold_active = 1'b0;

	initial begin
		for (int i = 0; i < LOOPS; i++) begin
			err_prev[i] = 0;
			err_prev2[i] = 0;
			duty_held[i] = '0;
		end
		in_bus.valid = 1'b0;
		in_bus.channel = 1'b0;
		in_bus.measured_speed = '0;
		in_bus.target_speed = '0;
	end

	// Clock, 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Velocity-form PID step for one sample; updates the loop history
	function automatic duty_result_t predict_duty(input sample_t s);
		int           loop_idx;
		longint       err;
		longint       acc;
		longint       val;
		duty_result_t res;
		loop_idx = int'(s.ch) % LOOPS;
		err = longint'(s.targ) - longint'(s.meas);
		acc = longint'(duty_held[loop_idx]) * 256
			+ longint'(gain_p) * (err - err_prev[loop_idx])
			+ longint'(gain_i) * err
			+ longint'(gain_d) * (err - 2 * err_prev[loop_idx] + err_prev2[loop_idx]);
		// signed division truncates toward zero
		val = acc / 256;
		res.limit = LIMIT_NONE;
		if (val > longint'(duty_ceil)) begin
			val = longint'(duty_ceil);
			res.limit = LIMIT_CEIL;
		end
		// floor wins when set above the ceiling
		if (val < longint'(duty_floor)) begin
			val = longint'(duty_floor);
			res.limit = LIMIT_FLOOR;
		end
		err_prev2[loop_idx] = err_prev[loop_idx];
		err_prev[loop_idx] = err;
		duty_held[loop_idx] = DUTY_W'(val);
		res.duty = DUTY_W'(val);
		return res;
	endfunction

	function automatic logic signed [SPEED_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return SPEED_MIN;
			1: return SPEED_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// Mostly tracking-loop samples near the target, plus noise and extremes
	function automatic sample_t draw_sample();
		sample_t s;
		int      mode;
		int      base;
		s.ch = 1'($urandom_range(0, 1));
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			base = $urandom_range(0, 4000) - 2000;
			s.targ = SPEED_W'(base);
			s.meas = SPEED_W'(base + $urandom_range(0, 128) - 64);
		end else if (mode < 8) begin
			s.targ = SPEED_W'($urandom);
			s.meas = SPEED_W'($urandom);
		end else if (mode == 8) begin
			s.targ = pick_extreme();
			s.meas = pick_extreme();
		end else begin
			s.targ = SPEED_W'($urandom);
			s.meas = s.targ;
		end
		return s;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("%0t MISMATCH result %0d: %s got %0d expected %0d",
			$realtime, results_seen, what, got, want);
	endtask

	// Directed table builders
	task automatic add_sample(input logic ch, input logic signed [SPEED_W-1:0] meas,
			input logic signed [SPEED_W-1:0] targ);
		stim_row_t r;
		r.kind = ROW_SAMPLE;
		r.smp.ch = ch;
		r.smp.meas = meas;
		r.smp.targ = targ;
		r.typed = 1'b0;
		r.res.duty = '0;
		r.res.limit = LIMIT_NONE;
		r.reg_index = '0;
		r.reg_data = '0;
		directed_rows.push_back(r);
	endtask

	task automatic add_checked(input logic ch, input logic signed [SPEED_W-1:0] meas,
			input logic signed [SPEED_W-1:0] targ, input logic [DUTY_W-1:0] duty,
			input limit_t limit);
		add_sample(ch, meas, targ);
		directed_rows[$].typed = 1'b1;
		directed_rows[$].res.duty = duty;
		directed_rows[$].res.limit = limit;
	endtask

	task automatic add_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind = ROW_WRITE;
		r.smp.ch = 1'b0;
		r.smp.meas = '0;
		r.smp.targ = '0;
		r.typed = 1'b0;
		r.res.duty = '0;
		r.res.limit = LIMIT_NONE;
		r.reg_index = idx;
		r.reg_data = data;
		directed_rows.push_back(r);
	endtask

	// Register write, one cycle of enable; mirrored into the predictor
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_GAIN_P:     gain_p = data;
			REG_GAIN_I:     gain_i = data;
			REG_GAIN_D:     gain_d = data;
			REG_DUTY_CEIL:  duty_ceil = data[DUTY_W-1:0];
			REG_DUTY_FLOOR: duty_floor = data[DUTY_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Offer one sample after a random gap; predict on acceptance
	task automatic send_sample(input sample_t s, input bit typed, input duty_result_t typed_res);
		int           gap;
		duty_result_t pred;
		gap = (no_idle || hold_request || hold_active) ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			in_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_bus.valid = 1'b1;
		in_bus.channel = s.ch;
		in_bus.measured_speed = s.meas;
		in_bus.target_speed = s.targ;
		do @(posedge clk); while (!in_bus.ready);
		pred = predict_duty(s);
		duty_expected.push_back(typed ? typed_res : pred);
	endtask

	// Drop valid and wait for every pending result
	task automatic drain();
		@(negedge clk);
		in_bus.valid = 1'b0;
		while (duty_expected.size() != 0) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		duty_result_t none;
		sample_t      s;
		none.duty = '0;
		none.limit = LIMIT_NONE;

		// reset defaults
		add_checked(1'b0, '0, '0, 8'd45, LIMIT_FLOOR);
		add_checked(1'b1, SPEED_MIN, SPEED_MAX, 8'd100, LIMIT_CEIL);
		add_checked(1'b1, SPEED_MAX, SPEED_MIN, 8'd45, LIMIT_FLOOR);
		add_checked(1'b0, '0, '0, 8'd45, LIMIT_NONE);
		add_sample(1'b0, 16'sd100, 16'sd140);
		add_sample(1'b0, 16'sd150, 16'sd140);
		// floor above ceiling always lands on the floor
		add_write(REG_DUTY_CEIL, 16'd50);
		add_write(REG_DUTY_FLOOR, 16'd200);
		add_checked(1'b1, 16'sd1234, -16'sd77, 8'd200, LIMIT_FLOOR);
		add_sample(1'b1, -16'sd300, 16'sd300);
		// zero band, then small negative sums truncate to zero
		add_write(REG_GAIN_P, 16'd0);
		add_write(REG_GAIN_I, 16'd1);
		add_write(REG_GAIN_D, 16'd0);
		add_write(REG_DUTY_CEIL, 16'd0);
		add_write(REG_DUTY_FLOOR, 16'd0);
		add_checked(1'b0, '0, '0, 8'd0, LIMIT_CEIL);
		add_write(REG_DUTY_CEIL, 16'd255);
		add_checked(1'b0, 16'sd1, '0, 8'd0, LIMIT_NONE);
		add_checked(1'b0, 16'sd256, '0, 8'd0, LIMIT_FLOOR);
		// full-scale gains
		add_write(REG_GAIN_P, 16'hFFFF);
		add_write(REG_GAIN_I, 16'hFFFF);
		add_write(REG_GAIN_D, 16'hFFFF);
		add_sample(1'b0, SPEED_MIN, SPEED_MAX);
		add_sample(1'b0, SPEED_MAX, SPEED_MIN);
		add_sample(1'b1, SPEED_MAX, SPEED_MAX);
		add_sample(1'b1, '1, SPEED_MIN);
		// back to typical gains, same loop back to back
		add_write(REG_GAIN_P, GAIN_P_RESET);
		add_write(REG_GAIN_I, GAIN_I_RESET);
		add_write(REG_GAIN_D, GAIN_D_RESET);
		add_sample(1'b1, 16'sd500, 16'sd520);
		add_sample(1'b1, 16'sd505, 16'sd520);
		add_sample(1'b1, 16'sd530, 16'sd520);
		add_sample(1'b1, 16'sd519, 16'sd520);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain();
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
			end else begin
				send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].res);
			end
		end

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			logic [GAIN_W-1:0] kp;
			logic [GAIN_W-1:0] ki;
			logic [GAIN_W-1:0] kd;
			logic [DUTY_W-1:0] ceil_v;
			logic [DUTY_W-1:0] floor_v;
			cfg_style_t        style;
			style = cfg_style_t'(p % 4);
			case (style)
				STYLE_TYPICAL: begin
					kp = GAIN_W'($urandom_range(0, 512));
					ki = GAIN_W'($urandom_range(0, 128));
					kd = GAIN_W'($urandom_range(0, 512));
					floor_v = DUTY_W'($urandom_range(0, 80));
					ceil_v = DUTY_W'($urandom_range(int'(floor_v) + 20, 255));
				end
				STYLE_RANDOM: begin
					kp = GAIN_W'($urandom);
					ki = GAIN_W'($urandom);
					kd = GAIN_W'($urandom);
					ceil_v = DUTY_W'($urandom);
					floor_v = DUTY_W'($urandom);
				end
				STYLE_EXTREME: begin
					kp = $urandom_range(0, 1) ? '1 : '0;
					ki = $urandom_range(0, 1) ? '1 : '0;
					kd = $urandom_range(0, 1) ? '1 : '0;
					ceil_v = $urandom_range(0, 1) ? '1 : '0;
					floor_v = $urandom_range(0, 1) ? '1 : '0;
				end
				default: begin
					kp = GAIN_P_RESET;
					ki = GAIN_I_RESET;
					kd = GAIN_D_RESET;
					ceil_v = '1;
					floor_v = '0;
				end
			endcase
			drain();
			no_idle = (p == 5);
			write_reg(REG_GAIN_P, kp);
			write_reg(REG_GAIN_I, ki);
			write_reg(REG_GAIN_D, kd);
			// upper data bits of the duty registers must be ignored
			write_reg(REG_DUTY_CEIL, {(CFG_DATA_W-DUTY_W)'($urandom), ceil_v});
			write_reg(REG_DUTY_FLOOR, {(CFG_DATA_W-DUTY_W)'($urandom), floor_v});
			if (p == 1)
				write_reg(REG_DUTY_FLOOR + CFG_INDEX_W'($urandom_range(1, 3)),
					CFG_DATA_W'($urandom));
			if (p == 2)
				hold_request = 1'b1;
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				// sender pause until the pipeline is empty
				if (p == 4 && n == RANDOM_ITEMS / PHASES / 2)
					drain();
				s = draw_sample();
				send_sample(s, 1'b0, none);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (duty_expected.size() != 0)
			report_mismatch("missing results", duty_expected.size(), 0);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side ready; one long stall on request
	initial begin
		int gap;
		out_bus.ready = 1'b0;
		wait (arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 4);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active = 1'b1;
				gap = HOLD_CYCLES;
			end
			@(negedge clk);
			if (gap > 0) begin
				out_bus.ready = 1'b0;
				repeat (gap) @(negedge clk);
				hold_active = 1'b0;
			end
			out_bus.ready = 1'b1;
			do @(posedge clk); while (!out_bus.valid);
		end
	end

	// Result checker
	always @(posedge clk) begin
		duty_result_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			results_seen++;
			if (duty_expected.size() == 0) begin
				report_mismatch("unexpected result, duty", out_bus.duty, 0);
			end else begin
				want = duty_expected.pop_front();
				if (out_bus.duty !== want.duty)
					report_mismatch("duty", out_bus.duty, want.duty);
				if (out_bus.limit_hit !== 2'(want.limit))
					report_mismatch("limit_hit", out_bus.limit_hit, want.limit);
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
sv/ipid_pkg.sv
sv/ipid_in_if.sv
sv/ipid_out_if.sv
sv/ipid_ram.sv
sv/incremental_pid_duty_controller_core.sv
sv/ipid_checker.sv
tb/tb_top.sv
